// ===== design/tiff_lzw_decoder_core_defines.svh =====
// ---------------------------------------------------------------------------
// tiff_lzw_decoder_core_defines.svh
// Assertion macros for the TIFF LZW decoder.
// ---------------------------------------------------------------------------
`ifndef TIFF_LZW_DECODER_CORE_DEFINES_SVH
`define TIFF_LZW_DECODER_CORE_DEFINES_SVH

`ifndef SYNTH
// checked while out of reset
`define TLZW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge
`define TLZW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLZW_ASSERT(lbl, prop, msg)
`define TLZW_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== design/tlzw_pkg.sv =====
// ---------------------------------------------------------------------------
// tlzw_pkg
// Shared types and constants of the TIFF LZW decoder.
// ---------------------------------------------------------------------------
package tlzw_pkg;

  localparam logic [11:0] CODE_CLEAR = 12'd256;
  localparam logic [11:0] CODE_END   = 12'd257;
  localparam logic [11:0] LIT_MAX    = 12'd255;
  localparam logic [12:0] FIRST_FREE = 13'd258;

  localparam logic [12:0] W10_AT = 13'd511;
  localparam logic [12:0] W11_AT = 13'd1023;
  localparam logic [12:0] W12_AT = 13'd2047;

  localparam logic [2:0] ST_RUN      = 3'd0;
  localparam logic [2:0] ST_OK       = 3'd1;
  localparam logic [2:0] ST_LEN      = 3'd2;
  localparam logic [2:0] ST_OVF      = 3'd3;
  localparam logic [2:0] ST_BADFIRST = 3'd4;
  localparam logic [2:0] ST_UNKNOWN  = 3'd5;
  localparam logic [2:0] ST_OVERRUN  = 3'd6;

  typedef struct packed {
    logic [11:0] prefix;
    logic [7:0]  last_char;
    logic [7:0]  first_char;
    logic [11:0] len;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic       load_item;
    logic       drain_rd;
    logic       drain_latch;
    logic       shift;
    logic       ent_rd_code;
    logic       add_look;
    logic       take_look;
    logic       add_kw;
    logic       clear_tbl;
    logic       emit;
    logic       walk_lit;
    logic       walk_rd;
    logic       walk_step;
    logic       set_st;
    logic       halt;
    logic [2:0] st_code;
    logic       finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic kind;
    logic halted;
    logic pending_nz;
    logic code_avail;
    logic code_is_clear;
    logic code_is_end;
    logic prev_valid;
    logic code_gt255;
    logic code_lt_nfc;
    logic code_eq_nfc;
    logic room;
    logic len_ok;
    logic ovf;
    logic walk_lit;
    logic walk_final;
    logic out_free;
  } stat_t;

  function automatic logic [3:0] width_for(input logic [12:0] nfc);
    logic [3:0] w;
    if (nfc >= W12_AT) w = 4'd12;
    else if (nfc >= W11_AT) w = 4'd11;
    else if (nfc >= W10_AT) w = 4'd10;
    else w = 4'd9;
    return w;
  endfunction

endpackage

// ===== design/tlzw_in_if.sv =====
// ---------------------------------------------------------------------------
// tlzw_in_if
// Input word channel: source bytes and drain requests.
// ---------------------------------------------------------------------------
interface tlzw_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] src_byte;
  logic       src_last;

  modport source (output valid, kind, src_byte, src_last, input ready);
  modport sink (input valid, kind, src_byte, src_last, output ready);
endinterface

// ===== design/tlzw_out_if.sv =====
// ---------------------------------------------------------------------------
// tlzw_out_if
// Result word channel: decoded byte and strip status.
// ---------------------------------------------------------------------------
interface tlzw_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] out_byte;
  logic       string_end;
  logic [2:0] status;

  modport source (output valid, byte_valid, out_byte, string_end, status, input ready);
  modport sink (input valid, byte_valid, out_byte, string_end, status, output ready);
endinterface

// ===== design/tlzw_ram.sv =====
// ---------------------------------------------------------------------------
// tlzw_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module tlzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/tlzw_ctrl.sv =====
// ---------------------------------------------------------------------------
// tlzw_ctrl
// Sequencer: dispatches one word, runs code handling and the chain walk.
// ---------------------------------------------------------------------------
module tlzw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tlzw_pkg::stat_t stat,
  output tlzw_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_DRAIN  = 4'd2;
  localparam logic [3:0] S_CODE   = 4'd3;
  localparam logic [3:0] S_LOOK   = 4'd4;
  localparam logic [3:0] S_EMIT   = 4'd5;
  localparam logic [3:0] S_WALK   = 4'd6;
  localparam logic [3:0] S_WALKRD = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.kind) begin
          if (stat.pending_nz) begin
            cmd.drain_rd = 1'b1;
            state_nxt    = S_DRAIN;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (stat.halted) begin
          state_nxt = S_DONE;
        end else if (stat.pending_nz) begin
          cmd.set_st  = 1'b1;
          cmd.halt    = 1'b1;
          cmd.st_code = tlzw_pkg::ST_OVERRUN;
          state_nxt   = S_DONE;
        end else begin
          cmd.shift = 1'b1;
          state_nxt = stat.code_avail ? S_CODE : S_DONE;
        end
      end
      S_DRAIN: begin
        cmd.drain_latch = 1'b1;
        state_nxt       = S_DONE;
      end
      S_CODE: begin
        state_nxt = S_DONE;
        if (stat.code_is_end) begin
          cmd.set_st  = 1'b1;
          cmd.halt    = 1'b1;
          cmd.st_code = stat.len_ok ? tlzw_pkg::ST_OK : tlzw_pkg::ST_LEN;
        end else if (stat.code_is_clear) begin
          cmd.clear_tbl = 1'b1;
        end else if (!stat.prev_valid && stat.code_gt255) begin
          cmd.set_st  = 1'b1;
          cmd.halt    = 1'b1;
          cmd.st_code = tlzw_pkg::ST_BADFIRST;
        end else if (!stat.prev_valid || stat.code_lt_nfc) begin
          cmd.ent_rd_code = 1'b1;
          state_nxt       = S_LOOK;
        end else if (stat.code_eq_nfc && stat.room) begin
          // code not yet in the table: prev string plus its own first char
          cmd.add_kw = 1'b1;
          state_nxt  = S_EMIT;
        end else begin
          cmd.set_st  = 1'b1;
          cmd.halt    = 1'b1;
          cmd.st_code = tlzw_pkg::ST_UNKNOWN;
        end
      end
      S_LOOK: begin
        cmd.take_look = 1'b1;
        cmd.add_look  = stat.prev_valid && stat.room;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (stat.ovf) begin
          cmd.set_st  = 1'b1;
          cmd.halt    = 1'b1;
          cmd.st_code = tlzw_pkg::ST_OVF;
          state_nxt   = S_DONE;
        end else begin
          cmd.emit  = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.walk_lit) begin
          cmd.walk_lit = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.walk_rd = 1'b1;
          state_nxt   = S_WALKRD;
        end
      end
      S_WALKRD: begin
        cmd.walk_step = 1'b1;
        state_nxt     = stat.walk_final ? S_DONE : S_WALK;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/tlzw_dp.sv =====
// ---------------------------------------------------------------------------
// tlzw_dp
// Datapath: bit unpacker, code table, string buffer, counters, result word.
// ---------------------------------------------------------------------------
module tlzw_dp #(
  parameter int TABLE_SIZE = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [31:0]     cfg_wdata,
  input  logic            in_kind,
  input  logic [7:0]      in_src_byte,
  input  logic            in_src_last,
  input  logic            out_rdy,
  output logic            out_vld,
  output logic            out_byte_valid,
  output logic [7:0]      out_byte,
  output logic            out_string_end,
  output logic [2:0]      out_status,
  input  tlzw_pkg::cmd_t  cmd,
  output tlzw_pkg::stat_t stat
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam logic [12:0] TS13 = 13'(TABLE_SIZE);

  logic [31:0] strip_len_r;
  logic        kind_r, last_r;
  logic [7:0]  byte_r;
  logic [18:0] bitbuf_r;
  logic [4:0]  bitcnt_r;
  logic [3:0]  width_r;
  logic [12:0] nfc_r;
  logic [11:0] prev_r;
  logic        prev_valid_r;
  logic [7:0]  prev_first_r;
  logic [11:0] prev_len_r;
  logic [31:0] be_r;
  logic [12:0] pending_r;
  logic        halted_r;
  logic [11:0] code_r;
  logic [11:0] shown_r;
  logic [7:0]  shown_first_r;
  logic [11:0] shown_len_r;
  logic [11:0] walk_r;
  logic [AW-1:0] k_r;
  logic        res_valid_r, res_end_r;
  logic [7:0]  res_byte_r;
  logic [2:0]  res_st_r;
  logic        out_vld_r, out_bv_r, out_end_r;
  logic [7:0]  out_byte_r;
  logic [2:0]  out_st_r;

  // bit unpacker
  logic [18:0] buf_sh, shifted, rem;
  logic [4:0]  cnt_sh, sh;
  logic [11:0] cmask, code_val;
  logic        code_avail;

  assign buf_sh     = {bitbuf_r[10:0], byte_r};
  assign cnt_sh     = bitcnt_r + 5'd8;
  assign code_avail = (cnt_sh >= {1'b0, width_r}) && (cnt_sh <= 5'd19);
  assign sh         = cnt_sh - {1'b0, width_r};
  assign shifted    = buf_sh >> sh;
  assign cmask      = 12'hFFF >> (4'd12 - width_r);
  assign code_val   = shifted[11:0] & cmask;
  assign rem        = buf_sh & ((19'd1 << sh) - 19'd1);

  // code table
  logic                ent_we, ent_re;
  logic [AW-1:0]       ent_raddr;
  tlzw_pkg::entry_t    ent_wdata, ent_rd;
  logic [7:0]          look_first;
  logic [11:0]         look_len, prev_len_p1;
  logic                code_lit;

  assign code_lit    = (code_r <= tlzw_pkg::LIT_MAX);
  assign look_first  = code_lit ? code_r[7:0] : ent_rd.first_char;
  assign look_len    = code_lit ? 12'd1 : ent_rd.len;
  assign prev_len_p1 = prev_len_r + 12'd1;

  assign ent_we    = cmd.add_look || cmd.add_kw;
  assign ent_re    = cmd.ent_rd_code || cmd.walk_rd;
  assign ent_raddr = cmd.walk_rd ? walk_r[AW-1:0] : code_r[AW-1:0];

  always_comb begin
    ent_wdata.prefix     = prev_r;
    ent_wdata.last_char  = cmd.add_kw ? prev_first_r : look_first;
    ent_wdata.first_char = prev_first_r;
    ent_wdata.len        = prev_len_p1;
  end

  tlzw_ram #(.WIDTH($bits(tlzw_pkg::entry_t)), .DEPTH(TABLE_SIZE)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (nfc_r[AW-1:0]),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rd)
  );

  // string buffer, held reversed
  logic          sb_we;
  logic [7:0]    sb_wdata, sb_rdata;
  logic [12:0]   pend_m1;

  assign sb_we    = cmd.walk_lit || cmd.walk_step;
  assign sb_wdata = cmd.walk_lit ? walk_r[7:0] : ent_rd.last_char;
  assign pend_m1  = pending_r - 13'd1;

  tlzw_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_string_ram (
    .clk   (clk),
    .we    (sb_we),
    .waddr (k_r),
    .wdata (sb_wdata),
    .re    (cmd.drain_rd),
    .raddr (pend_m1[AW-1:0]),
    .rdata (sb_rdata)
  );

  logic len_ok;
  assign len_ok = (be_r == strip_len_r);

  always_comb begin
    stat.kind          = kind_r;
    stat.halted        = halted_r;
    stat.pending_nz    = (pending_r != 13'd0);
    stat.code_avail    = code_avail;
    stat.code_is_clear = (code_r == tlzw_pkg::CODE_CLEAR);
    stat.code_is_end   = (code_r == tlzw_pkg::CODE_END);
    stat.prev_valid    = prev_valid_r;
    stat.code_gt255    = !code_lit;
    stat.code_lt_nfc   = ({1'b0, code_r} < nfc_r);
    stat.code_eq_nfc   = ({1'b0, code_r} == nfc_r);
    stat.room          = (nfc_r < TS13);
    stat.len_ok        = len_ok;
    stat.ovf           = ({1'b0, be_r} + 33'(shown_len_r)) > {1'b0, strip_len_r};
    stat.walk_lit      = (walk_r <= tlzw_pkg::LIT_MAX);
    stat.walk_final    = ((13'(k_r) + 13'd1) == {1'b0, shown_len_r});
    stat.out_free      = !out_vld_r || out_rdy;
  end

  logic       restart;
  logic [2:0] fin_st;
  assign restart = cmd.finish && last_r && !kind_r;
  assign fin_st  = (last_r && !kind_r && !halted_r) ? (len_ok ? tlzw_pkg::ST_OK : tlzw_pkg::ST_LEN)
                                                    : res_st_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_len_r  <= '0;
      bitbuf_r     <= '0;
      bitcnt_r     <= '0;
      width_r      <= 4'd9;
      nfc_r        <= tlzw_pkg::FIRST_FREE;
      prev_r       <= '0;
      prev_valid_r <= 1'b0;
      be_r         <= '0;
      pending_r    <= '0;
      halted_r     <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        strip_len_r <= cfg_wdata;
      end
      if (cmd.shift) begin
        bitbuf_r <= code_avail ? rem : buf_sh;
        bitcnt_r <= code_avail ? sh : cnt_sh;
      end
      if (cmd.drain_rd) begin
        pending_r <= pend_m1;
      end
      if (cmd.set_st && cmd.halt) begin
        halted_r <= 1'b1;
      end
      if (cmd.clear_tbl) begin
        nfc_r        <= tlzw_pkg::FIRST_FREE;
        width_r      <= 4'd9;
        prev_r       <= '0;
        prev_valid_r <= 1'b0;
      end
      if (ent_we) begin
        nfc_r <= nfc_r + 13'd1;
      end
      if (cmd.emit) begin
        pending_r    <= {1'b0, shown_len_r};
        be_r         <= be_r + 32'(shown_len_r);
        prev_r       <= shown_r;
        prev_valid_r <= 1'b1;
        width_r      <= tlzw_pkg::width_for(nfc_r);
      end
      // a new result refills the register in the cycle the old one leaves
      if (cmd.finish) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && out_rdy) begin
        out_vld_r <= 1'b0;
      end
      if (restart) begin
        nfc_r        <= tlzw_pkg::FIRST_FREE;
        width_r      <= 4'd9;
        prev_r       <= '0;
        prev_valid_r <= 1'b0;
        bitbuf_r     <= '0;
        bitcnt_r     <= '0;
        be_r         <= '0;
        halted_r     <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_r      <= in_kind;
      byte_r      <= in_src_byte;
      last_r      <= in_src_last;
      res_valid_r <= 1'b0;
      res_end_r   <= 1'b0;
      res_byte_r  <= '0;
      res_st_r    <= tlzw_pkg::ST_RUN;
    end
    if (cmd.shift) begin
      code_r <= code_val;
    end
    if (cmd.drain_rd) begin
      res_valid_r <= 1'b1;
      res_end_r   <= (pending_r == 13'd1);
    end
    if (cmd.drain_latch) begin
      res_byte_r <= sb_rdata;
    end
    if (cmd.set_st) begin
      res_st_r <= cmd.st_code;
    end
    if (cmd.take_look) begin
      shown_r       <= code_r;
      shown_first_r <= look_first;
      shown_len_r   <= look_len;
    end
    if (cmd.add_kw) begin
      shown_r       <= nfc_r[11:0];
      shown_first_r <= prev_first_r;
      shown_len_r   <= prev_len_p1;
    end
    if (cmd.emit) begin
      prev_first_r <= shown_first_r;
      prev_len_r   <= shown_len_r;
      walk_r       <= shown_r;
      k_r          <= '0;
    end
    if (cmd.walk_step) begin
      walk_r <= ent_rd.prefix;
      k_r    <= k_r + 1'b1;
    end
    if (cmd.finish) begin
      out_bv_r   <= res_valid_r;
      out_byte_r <= res_byte_r;
      out_end_r  <= res_end_r;
      out_st_r   <= fin_st;
    end
  end

  assign out_vld        = out_vld_r;
  assign out_byte_valid = out_bv_r;
  assign out_byte       = out_byte_r;
  assign out_string_end = out_end_r;
  assign out_status     = out_st_r;

endmodule

// ===== design/tiff_lzw_decoder_core.sv =====
// ---------------------------------------------------------------------------
// tiff_lzw_decoder_core
// TIFF LZW strip decoder, 9 to 12 bit codes with early width change.
// ---------------------------------------------------------------------------
// Usage:
//  - in_ch carries one word per item: kind 0 is a compressed strip byte,
//    kind 1 drains one pending decoded byte. Exactly one result word goes
//    out on out_ch for every input word, in order.
//  - cfg_we/cfg_wdata load strip_length; write it while the block is idle.
//  - A word is taken only when the sequencer is idle; one word at a time.
//    A drain reads the string RAM. A byte that completes a code also walks
//    the prefix chain through the table RAM, one entry read and then one
//    string RAM write per string byte.
//  - The result sits in an output register, so a stalled receiver does not
//    block intake of the next word; it only holds the sequencer in its
//    final state until that register frees up.
//  - Reset (rst_n, synchronous) empties the table, bit buffer and counts
//    and clears strip_length. Literal table entries are implied, so no
//    clearing pass is needed.
//  - The strip's last source byte restarts the decoder; pending output
//    stays available for draining.
// ---------------------------------------------------------------------------
`include "tiff_lzw_decoder_core_defines.svh"

module tiff_lzw_decoder_core #(
  parameter int TABLE_SIZE = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  tlzw_in_if.sink            in_ch,
  tlzw_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata
);

  tlzw_pkg::cmd_t  cmd;
  tlzw_pkg::stat_t stat;
  logic            in_rdy;

  assign in_ch.ready = in_rdy;

  // sequencer
  tlzw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_rdy),
    .stat     (stat),
    .cmd      (cmd)
  );

  // unpacker, table, string buffer and result register
  tlzw_dp #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_kind        (in_ch.kind),
    .in_src_byte    (in_ch.src_byte),
    .in_src_last    (in_ch.src_last),
    .out_rdy        (out_ch.ready),
    .out_vld        (out_ch.valid),
    .out_byte_valid (out_ch.byte_valid),
    .out_byte       (out_ch.out_byte),
    .out_string_end (out_ch.string_end),
    .out_status     (out_ch.status),
    .cmd            (cmd),
    .stat           (stat)
  );

  // one word in flight: intake closes right after a word is taken
  `TLZW_ASSERT(a_one_in_flight, in_ch.valid && in_ch.ready |=> !in_ch.ready, "second word taken while busy")
  // a string end only comes with a decoded byte
  `TLZW_ASSERT(a_end_has_byte, out_ch.valid && out_ch.string_end |-> out_ch.byte_valid, "string end without byte")
  // status words never carry a byte
  `TLZW_ASSERT(a_status_no_byte, out_ch.valid && (out_ch.status != tlzw_pkg::ST_RUN) |-> !out_ch.byte_valid, "byte with status")
  // nothing leaves during reset
  `TLZW_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_ch.valid, "result after reset")

endmodule
